// ===== design/gregorian_days_between_unit_macros.svh =====
// Assertion macros shared by the files that check the days-between unit.
// Depends on nothing; the user provides clk_i and rst_ni in scope.
`ifndef GREGORIAN_DAYS_BETWEEN_UNIT_MACROS_SVH
`define GREGORIAN_DAYS_BETWEEN_UNIT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define GDB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define GDB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/gdb_pkg.sv =====
// Types, widths and the month table for the Gregorian days-between unit.
// Depends on nothing.
package gdb_pkg;

  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned DAYS_W    = 22;
  // Day numbers run from -365 up to about 5.98 million.
  localparam int unsigned DAY_NUM_W = 24;
  localparam int unsigned MDAYS_W   = 9;
  localparam int unsigned Q100_W    = 8;
  localparam int unsigned DIFF_W    = DAY_NUM_W + 1;

  // Register stages inside one day-number pipeline; the valid bits and swap
  // flags that run beside it use the same depth.
  localparam int unsigned DN_STAGES = 3;

  // x / 100 == (x * 5243) >> 19 holds exactly for every x below 43699.
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned RECIP_W     = 27;
  localparam int unsigned DAYS_PER_YR = 365;
  localparam int unsigned HUNDRED     = 100;

  localparam logic [DAYS_W-1:0] DAYS_MAX = {DAYS_W{1'b1}};
  localparam logic signed [DAY_NUM_W-1:0] YEAR0_BASE = -24'sd365;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // Days of all months before the given one in a common year. Month zero and
  // one add nothing; months above twelve add the whole year.
  function automatic logic [MDAYS_W-1:0] cum_days(input logic [MONTH_W-1:0] month);
    logic [MDAYS_W-1:0] res;
    case (month)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd0;
      4'd2:    res = 9'd31;
      4'd3:    res = 9'd59;
      4'd4:    res = 9'd90;
      4'd5:    res = 9'd120;
      4'd6:    res = 9'd151;
      4'd7:    res = 9'd181;
      4'd8:    res = 9'd212;
      4'd9:    res = 9'd243;
      4'd10:   res = 9'd273;
      4'd11:   res = 9'd304;
      4'd12:   res = 9'd334;
      default: res = 9'd365;
    endcase
    return res;
  endfunction

endpackage

// ===== design/gdb_day_number.sv =====
// Three-stage pipeline that turns one date into its proleptic day number.
// Depends on gdb_pkg.
module gdb_day_number (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  gdb_pkg::date_t                        date_i,
  output logic signed [gdb_pkg::DAY_NUM_W-1:0]  day_num_o
);

  // Stage A: year minus one, its multiple of 365 and the quotients by 100.
  logic [gdb_pkg::YEAR_W-1:0]    p_a;
  logic [gdb_pkg::RECIP_W-1:0]   prod_p_a, prod_y_a;
  logic [gdb_pkg::DAY_NUM_W-2:0] a365_d, a365_q;
  logic [gdb_pkg::YEAR_W-3:0]    p4_d, p4_q;
  logic [gdb_pkg::Q100_W-1:0]    q100p_d, q100p_q, q100y_d, q100y_q;
  logic [gdb_pkg::YEAR_W-1:0]    year_a_q;
  logic                          yz_d, yz_q;
  logic [gdb_pkg::MONTH_W-1:0]   month_a_q;
  logic [gdb_pkg::DAY_W-1:0]     day_a_q;

  always_comb begin
    p_a      = date_i.year - gdb_pkg::YEAR_W'(1);
    yz_d     = (date_i.year == '0);
    a365_d   = (gdb_pkg::DAY_NUM_W-1)'(p_a) * (gdb_pkg::DAY_NUM_W-1)'(gdb_pkg::DAYS_PER_YR);
    p4_d     = p_a[gdb_pkg::YEAR_W-1:2];
    prod_p_a = gdb_pkg::RECIP_W'(p_a) * gdb_pkg::RECIP_W'(gdb_pkg::RECIP_100);
    prod_y_a = gdb_pkg::RECIP_W'(date_i.year) * gdb_pkg::RECIP_W'(gdb_pkg::RECIP_100);
    q100p_d  = gdb_pkg::Q100_W'(prod_p_a >> gdb_pkg::RECIP_SHIFT);
    q100y_d  = gdb_pkg::Q100_W'(prod_y_a >> gdb_pkg::RECIP_SHIFT);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a365_q    <= a365_d;
      p4_q      <= p4_d;
      q100p_q   <= q100p_d;
      q100y_q   <= q100y_d;
      year_a_q  <= date_i.year;
      yz_q      <= yz_d;
      month_a_q <= date_i.month;
      day_a_q   <= date_i.day;
    end
  end

  // Stage B: leap year test, year part and month part.
  logic                                 hund_b, leap_b;
  logic [gdb_pkg::MDAYS_W-1:0]          mdays_d, mdays_q;
  logic [gdb_pkg::DAY_NUM_W-1:0]        year_sum_b;
  logic signed [gdb_pkg::DAY_NUM_W-1:0] ypart_d, ypart_q;
  logic [gdb_pkg::DAY_W-1:0]            day_b_q;

  always_comb begin
    hund_b = ((gdb_pkg::YEAR_W+1)'(q100y_q) * (gdb_pkg::YEAR_W+1)'(gdb_pkg::HUNDRED))
             == (gdb_pkg::YEAR_W+1)'(year_a_q);
    leap_b = ((year_a_q[1:0] == 2'd0) && !hund_b) || (hund_b && (q100y_q[1:0] == 2'd0));
    mdays_d = gdb_pkg::cum_days(month_a_q);
    if (leap_b && (month_a_q >= gdb_pkg::MONTH_MAR)) begin
      mdays_d = mdays_d + gdb_pkg::MDAYS_W'(1);
    end
    year_sum_b = gdb_pkg::DAY_NUM_W'(a365_q) + gdb_pkg::DAY_NUM_W'(p4_q)
                 - gdb_pkg::DAY_NUM_W'(q100p_q) + gdb_pkg::DAY_NUM_W'(q100p_q >> 2);
    ypart_d = yz_q ? gdb_pkg::YEAR0_BASE : $signed(year_sum_b);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ypart_q <= ypart_d;
      mdays_q <= mdays_d;
      day_b_q <= day_a_q;
    end
  end

  // Stage C: final sum.
  logic signed [gdb_pkg::DAY_NUM_W-1:0] dn_d, dn_q;

  always_comb begin
    dn_d = ypart_q + $signed(gdb_pkg::DAY_NUM_W'(mdays_q))
           + $signed(gdb_pkg::DAY_NUM_W'(day_b_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dn_q <= dn_d;
    end
  end

  assign day_num_o = dn_q;

endmodule

// ===== design/gregorian_days_between_unit.sv =====
// Top level of the Gregorian days-between unit: input skid, ordering stage,
// two day-number pipelines and the saturating difference. Depends on gdb_pkg.
//
// The unit takes a pair of proleptic Gregorian dates per request and returns
// the number of days from the earlier to the later one, with a flag that is
// set when the first date was the later one. Dates are ordered by year, then
// month, then day; days are not checked against the month length, so an
// ordered pair can give a negative count, which is reported as zero. Counts
// above the output range saturate at all ones. Year zero counts as a leap
// year whose day numbers start 365 days before year one. The unit accepts one
// request every clock cycle when the output side does not stall; each result
// passes one ordering stage, three stages in each day-number pipeline and one
// difference stage. A stall on the output while a result is held freezes
// every stage; one request that arrives in that cycle is held in a skid
// register, and stall_o, which is a register, rises the cycle after so that
// the input side never sees a combinational path from stall_i.
module gregorian_days_between_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [gdb_pkg::YEAR_W-1:0]    first_year_i,
  input  logic [gdb_pkg::MONTH_W-1:0]   first_month_i,
  input  logic [gdb_pkg::DAY_W-1:0]     first_day_i,
  input  logic [gdb_pkg::YEAR_W-1:0]    second_year_i,
  input  logic [gdb_pkg::MONTH_W-1:0]   second_month_i,
  input  logic [gdb_pkg::DAY_W-1:0]     second_day_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [gdb_pkg::DAYS_W-1:0]    days_between_o,
  output logic                          swapped_o
);

  logic en;
  logic out_v_q;

  // The whole pipeline moves unless a finished result is being held.
  assign en = !(out_v_q && stall_i);

  // Input skid register.
  logic           acc_in;
  logic           skid_v_d, skid_v_q;
  gdb_pkg::date_t in_first, in_second;
  gdb_pkg::date_t skid_first_q, skid_second_q;
  gdb_pkg::date_t src_first, src_second;
  logic           src_v;

  always_comb begin
    in_first  = '{year: first_year_i, month: first_month_i, day: first_day_i};
    in_second = '{year: second_year_i, month: second_month_i, day: second_day_i};
    acc_in    = valid_i && !skid_v_q;
    src_v      = skid_v_q || acc_in;
    src_first  = skid_v_q ? skid_first_q : in_first;
    src_second = skid_v_q ? skid_second_q : in_second;
    // A request caught during a stall waits here until the pipeline moves.
    if (skid_v_q) begin
      skid_v_d = !en;
    end else begin
      skid_v_d = acc_in && !en;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in && !en) begin
      skid_first_q  <= in_first;
      skid_second_q <= in_second;
    end
  end

  assign stall_o = skid_v_q;

  // Ordering stage. Comparing the packed dates as one number gives the
  // year-month-day order directly.
  logic           swap_d;
  gdb_pkg::date_t early_d, late_d, early_q, late_q;
  logic           s1_v_q, s1_swap_q;

  always_comb begin
    swap_d  = src_first > src_second;
    early_d = swap_d ? src_second : src_first;
    late_d  = swap_d ? src_first : src_second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= src_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      early_q   <= early_d;
      late_q    <= late_d;
      s1_swap_q <= swap_d;
    end
  end

  // Day numbers for both dates.
  logic signed [gdb_pkg::DAY_NUM_W-1:0] early_num, late_num;

  gdb_day_number u_early (
    .clk_i     (clk_i),
    .en_i      (en),
    .date_i    (early_q),
    .day_num_o (early_num)
  );

  gdb_day_number u_late (
    .clk_i     (clk_i),
    .en_i      (en),
    .date_i    (late_q),
    .day_num_o (late_num)
  );

  // Valid bits and swap flags that travel beside the day-number pipelines.
  logic [gdb_pkg::DN_STAGES-1:0] dn_v_q;
  logic [gdb_pkg::DN_STAGES-1:0] dn_swap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dn_v_q <= '0;
    end else if (en) begin
      dn_v_q <= {dn_v_q[gdb_pkg::DN_STAGES-2:0], s1_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dn_swap_q <= {dn_swap_q[gdb_pkg::DN_STAGES-2:0], s1_swap_q};
    end
  end

  // Difference stage and output register.
  logic signed [gdb_pkg::DIFF_W-1:0] diff;
  logic [gdb_pkg::DAYS_W-1:0]        days_d, days_q;
  logic                              swap_out_q;

  always_comb begin
    diff = gdb_pkg::DIFF_W'(late_num) - gdb_pkg::DIFF_W'(early_num);
    if (diff < 0) begin
      days_d = '0;
    end else if (diff > $signed(gdb_pkg::DIFF_W'(gdb_pkg::DAYS_MAX))) begin
      days_d = gdb_pkg::DAYS_MAX;
    end else begin
      days_d = diff[gdb_pkg::DAYS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dn_v_q[gdb_pkg::DN_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      days_q     <= days_d;
      swap_out_q <= dn_swap_q[gdb_pkg::DN_STAGES-1];
    end
  end

  assign valid_o        = out_v_q;
  assign days_between_o = days_q;
  assign swapped_o      = swap_out_q;

endmodule

// ===== design/gdb_checker.sv =====
// Port-level checks for the days-between unit, bound to its top level.
// Depends on gdb_pkg and gregorian_days_between_unit_macros.svh.
`include "gregorian_days_between_unit_macros.svh"

module gdb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          valid_i,
  input logic                          stall_o,
  input logic [gdb_pkg::YEAR_W-1:0]    first_year_i,
  input logic [gdb_pkg::MONTH_W-1:0]   first_month_i,
  input logic [gdb_pkg::DAY_W-1:0]     first_day_i,
  input logic [gdb_pkg::YEAR_W-1:0]    second_year_i,
  input logic [gdb_pkg::MONTH_W-1:0]   second_month_i,
  input logic [gdb_pkg::DAY_W-1:0]     second_day_i,
  input logic                          valid_o,
  input logic                          stall_i,
  input logic [gdb_pkg::DAYS_W-1:0]    days_between_o,
  input logic                          swapped_o
);

  logic                        same_dates;
  logic                        out_held;
  logic                        eq_req;
  logic                        eq_result;
  logic [gdb_pkg::DAYS_W:0]    out_word;

  assign same_dates = (first_year_i == second_year_i) && (first_month_i == second_month_i)
                      && (first_day_i == second_day_i);
  assign out_held   = valid_o && stall_i;
  assign out_word   = {days_between_o, swapped_o};
  assign eq_req     = valid_i && !stall_o && same_dates && !stall_i;
  assign eq_result  = valid_o && (days_between_o == '0) && !swapped_o;

  // A held result keeps its payload.
  `GDB_ASSERT(a_out_hold, out_held |=> valid_o && $stable(out_word), "held result changed")

  // The input side is only held off after the output side held a result.
  `GDB_ASSERT(a_stall_cause, $rose(stall_o) |-> $past(out_held), "stall without output stall")

  // Equal dates give a zero count, unswapped, when the output side does not stall meanwhile.
  `GDB_ASSERT(a_equal_dates, eq_req ##1 !stall_i [*4] |=> eq_result, "equal dates wrong")

  // A cycle spent in reset leaves nothing to deliver and nothing held after it.
  `GDB_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !valid_o && !stall_o, "not empty after reset")

endmodule

bind gregorian_days_between_unit gdb_checker u_gdb_checker (.*);

// ===== verif/tb.sv =====
// Self-checking testbench for gregorian_days_between_unit: directed corners,
// random date pairs, back-pressure and streaming. Depends on gdb_pkg and the unit.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_PAIRS = 1080;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int MONTH_LENGTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    gdb_pkg::date_t             first;
    gdb_pkg::date_t             second;
    logic [gdb_pkg::DAYS_W-1:0] days;
    logic                       swapped;
  } span_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          valid_i = 1'b0;
  logic                          stall_i = 1'b0;
  logic [gdb_pkg::YEAR_W-1:0]    first_year_i = '0;
  logic [gdb_pkg::MONTH_W-1:0]   first_month_i = '0;
  logic [gdb_pkg::DAY_W-1:0]     first_day_i = '0;
  logic [gdb_pkg::YEAR_W-1:0]    second_year_i = '0;
  logic [gdb_pkg::MONTH_W-1:0]   second_month_i = '0;
  logic [gdb_pkg::DAY_W-1:0]     second_day_i = '0;
  logic                          stall_o;
  logic                          valid_o;
  logic [gdb_pkg::DAYS_W-1:0]    days_between_o;
  logic                          swapped_o;

  span_t pending_spans[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // When set, neither side inserts idle cycles.
  bit no_idle = 1'b0;

  // Long receiver hold-off: the test flips hold_token, the hold process
  // notices the change and counts the stall down by itself.
  logic hold_token = 1'b0;
  logic hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  gregorian_days_between_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .first_year_i  (first_year_i),
    .first_month_i (first_month_i),
    .first_day_i   (first_day_i),
    .second_year_i (second_year_i),
    .second_month_i(second_month_i),
    .second_day_i  (second_day_i),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .days_between_o(days_between_o),
    .swapped_o     (swapped_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Proleptic day number of one date. Year zero gives p = -1, and the
  // divisions truncate toward zero just as the hardware is meant to.
  function automatic longint day_ordinal(gdb_pkg::date_t dt);
    longint p;
    longint total;
    int     yr;
    int     last_month;
    bit     leap;
    yr = int'(dt.year);
    p = longint'(yr) - 1;
    total = p * 365 + p / 4 - p / 100 + p / 400;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    // Months above twelve add the whole year, month zero adds nothing.
    last_month = (dt.month > 13) ? 13 : int'(dt.month);
    for (int i = 0; i < last_month - 1; i++) begin
      total += MONTH_LENGTH[i];
      if (i == 1 && leap) begin
        total += 1;
      end
    end
    return total + longint'(dt.day);
  endfunction

  // Orders the pair by year, month, day and returns the clamped distance.
  function automatic span_t predict_span(gdb_pkg::date_t first, gdb_pkg::date_t second);
    span_t  sp;
    longint diff;
    sp.first = first;
    sp.second = second;
    if (first.year != second.year) begin
      sp.swapped = first.year > second.year;
    end else if (first.month != second.month) begin
      sp.swapped = first.month > second.month;
    end else begin
      sp.swapped = first.day > second.day;
    end
    if (sp.swapped) begin
      diff = day_ordinal(first) - day_ordinal(second);
    end else begin
      diff = day_ordinal(second) - day_ordinal(first);
    end
    // An unchecked day can put the later date before the earlier one.
    if (diff < 0) begin
      diff = 0;
    end
    if (diff > longint'(gdb_pkg::DAYS_MAX)) begin
      diff = longint'(gdb_pkg::DAYS_MAX);
    end
    sp.days = diff[gdb_pkg::DAYS_W-1:0];
    return sp;
  endfunction

  function automatic gdb_pkg::date_t make_date(int yr, int mo, int dy);
    gdb_pkg::date_t dt;
    dt.year = yr[gdb_pkg::YEAR_W-1:0];
    dt.month = mo[gdb_pkg::MONTH_W-1:0];
    dt.day = dy[gdb_pkg::DAY_W-1:0];
    return dt;
  endfunction

  // Offers one request after a random idle gap and returns at the clock edge
  // where it is accepted. Valid stays high into the next call when that call
  // draws no gap, so back-to-back requests never drop valid in between.
  task automatic send_dates(input gdb_pkg::date_t first, input gdb_pkg::date_t second);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    first_year_i <= first.year;
    first_month_i <= first.month;
    first_day_i <= first.day;
    second_year_i <= second.year;
    second_month_i <= second.month;
    second_day_i <= second.day;
    do begin
      @(posedge clk_i);
    end while (stall_o);
    pending_spans.push_back(predict_span(first, second));
  endtask

  // Mostly years 1 to 9999, months 1 to 12 and days 1 to 31, the rest anything the field widths allow.
  function automatic gdb_pkg::date_t random_date();
    if ($urandom_range(0, 9) < 6) begin
      return make_date($urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 31));
    end
    return make_date($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
  endfunction

  // Second date near the first, so that the month and day comparisons often decide.
  function automatic gdb_pkg::date_t nearby_date(gdb_pkg::date_t base);
    gdb_pkg::date_t dt;
    dt = base;
    case ($urandom_range(0, 3))
      0: dt.day = gdb_pkg::DAY_W'($urandom_range(0, 31));
      1: dt.month = gdb_pkg::MONTH_W'($urandom_range(0, 15));
      2: dt.year = gdb_pkg::YEAR_W'(int'(base.year) + int'($urandom_range(0, 2)) - 1);
      default: dt = base;
    endcase
    return dt;
  endfunction

  task automatic test_directed_corners();
    send_dates(make_date(2024, 5, 17), make_date(2024, 5, 17));
    send_dates(make_date(1, 1, 1), make_date(9999, 12, 31));
    send_dates(make_date(9999, 12, 31), make_date(1, 1, 1));
    send_dates(make_date(1, 1, 1), make_date(16383, 15, 31));
    send_dates(make_date(16383, 15, 31), make_date(0, 0, 0));
    send_dates(make_date(0, 1, 1), make_date(1, 1, 1));
    send_dates(make_date(0, 3, 1), make_date(0, 2, 28));
    send_dates(make_date(0, 0, 0), make_date(0, 0, 31));
    send_dates(make_date(2023, 0, 5), make_date(2023, 1, 5));
    send_dates(make_date(2023, 13, 1), make_date(2024, 1, 1));
    send_dates(make_date(2024, 15, 0), make_date(2024, 12, 31));
    send_dates(make_date(2023, 2, 30), make_date(2023, 3, 1));
    send_dates(make_date(2023, 3, 1), make_date(2023, 2, 31));
    send_dates(make_date(2000, 2, 29), make_date(2000, 3, 1));
    send_dates(make_date(1900, 2, 28), make_date(1900, 3, 1));
    send_dates(make_date(2004, 3, 1), make_date(2004, 2, 28));
    send_dates(make_date(2100, 1, 1), make_date(2101, 1, 1));
    send_dates(make_date(1600, 12, 31), make_date(1601, 1, 0));
    send_dates(make_date(8191, 7, 16), make_date(8192, 8, 15));
  endtask

  task automatic test_random_dates(input int unsigned count);
    gdb_pkg::date_t a;
    gdb_pkg::date_t b;
    for (int unsigned n = 0; n < count; n++) begin
      // Every so often run a stretch with no idle cycles on either side.
      no_idle = (n % 150) >= 120;
      a = random_date();
      b = ($urandom_range(0, 2) == 0) ? nearby_date(a) : random_date();
      send_dates(a, b);
    end
    no_idle = 1'b0;
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the pipeline and its skid register fill and stall_o rises.
  task automatic test_backpressure();
    hold_token <= ~hold_token;
    no_idle = 1'b1;
    for (int n = 0; n < 40; n++) begin
      send_dates(random_date(), random_date());
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: after each accepted result it draws a random stall length.
  always @(posedge clk_i) begin
    if (valid_o && !stall_i) begin
      stall_left = no_idle ? 0 : $urandom_range(0, 14);
    end
    if (hold_left != 0) begin
      stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      stall_i <= 1'b1;
    end else begin
      stall_i <= 1'b0;
    end
  end

  // Result checker: each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    span_t sp;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_spans.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("unexpected result: days %0d swapped %0b", days_between_o, swapped_o);
        end
      end else begin
        sp = pending_spans.pop_front();
        if (days_between_o !== sp.days || swapped_o !== sp.swapped) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch %0d-%0d-%0d vs %0d-%0d-%0d: days exp %0d got %0d,",
                     sp.first.year, sp.first.month, sp.first.day,
                     sp.second.year, sp.second.month, sp.second.day,
                     sp.days, days_between_o);
            $display("  swapped exp %0b got %0b", sp.swapped, swapped_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_random_dates(RANDOM_PAIRS / 2);
    test_backpressure();
    test_random_dates(RANDOM_PAIRS / 2);
    valid_i <= 1'b0;

    while (pending_spans.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
